>>> rtl/doc_pkg.sv
`default_nettype none
package doc_pkg;

  localparam int PIXELS = 65536;
  localparam int IDX_W = 16;
  localparam int PIX_W = 16;
  localparam int SUM_W = 24;
  localparam int COEFF_W = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MAX_DARK_FRAMES = 256;
  localparam int DIV_W = 32;
  localparam int DIV_BITS = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH = 32;
  localparam int COEFF_MAX = 1048575;
  localparam int COEFF_MIN = -1048576;

  typedef enum logic [1:0] {
    OP_ACCUMULATE = 2'd0,
    OP_CORRECT    = 2'd1,
    OP_LOAD       = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_CAL   = 2'd1,
    STATUS_BAD_DEPTH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    KIND_ACC,
    KIND_ACC_BAD,
    KIND_CORRECT,
    KIND_LOAD,
    KIND_NONE
  } kind_t;

  typedef enum logic [2:0] {
    REG_TARGET,
    REG_DEPTH,
    REG_FRAMES,
    REG_SCALE_EN,
    REG_SCALE,
    REG_ACTIVE
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] target_baseline;
    logic [4:0]  bit_depth;
    logic [8:0]  dark_frame_count;
    logic        scale_enable;
    logic [15:0] scale_factor;
    logic [16:0] active_pixels;
  } cfg_t;

  typedef struct packed {
    kind_t                     kind;
    logic [IDX_W-1:0]          idx;
    logic [PIX_W-1:0]          pix;
    logic                      first;
    logic                      last;
    logic signed [COEFF_W-1:0] coeff;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/doc_front.sv
`default_nettype none
module doc_front
  import doc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfg_t                      cfg,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [1:0]                operation,
  input  wire logic [IDX_W-1:0]          pixel_index,
  input  wire logic [PIX_W-1:0]          pixel_value,
  input  wire logic                      first_dark_frame,
  input  wire logic                      last_dark_frame,
  input  wire logic signed [COEFF_W-1:0] coefficient_in,
  output logic                           q_valid,
  output item_t                          q_item,
  input  wire logic                      q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            queue [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   cnt;
  item_t            item;
  logic             depth_ok;
  logic             wr;
  logic             rd;

  assign depth_ok = (cfg.bit_depth == 5'd12) || (cfg.bit_depth == 5'd14) ||
                    (cfg.bit_depth == 5'd16);

  always_comb begin
    item.idx   = pixel_index;
    item.pix   = pixel_value;
    item.first = first_dark_frame;
    item.last  = last_dark_frame;
    item.coeff = coefficient_in;
    case (op_t'(operation))
      OP_ACCUMULATE: item.kind = depth_ok ? KIND_ACC : KIND_ACC_BAD;
      OP_CORRECT:    item.kind = KIND_CORRECT;
      OP_LOAD:       item.kind = KIND_LOAD;
      default:       item.kind = KIND_NONE;
    endcase
  end

  assign full    = (cnt == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt != '0);
  assign q_item  = queue[rp];
  assign wr      = push && !full;
  assign rd      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      queue[wp] <= item;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/doc_div.sv
`default_nettype none
module doc_div
  import doc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [8:0]       divisor,
  input  wire logic [DIV_W-1:0] dividend,
  output logic [DIV_W-1:0]      quotient
);

  typedef struct packed {
    logic [8:0]       rem;
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] quo;
  } div_state_t;

  function automatic div_state_t div_step(input div_state_t s, input logic [8:0] n);
    div_state_t r;
    logic [9:0] t;
    r = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r.rem, r.dvd[DIV_W-1]};
      r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
        r.quo = {r.quo[DIV_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[DIV_W-2:0], 1'b0};
      end
      r.rem = t[8:0];
    end
    return r;
  endfunction

  div_state_t stage [0:DIV_STAGES-1];
  div_state_t start;

  assign start = '{rem: '0, dvd: dividend, quo: '0};

  always_ff @(posedge clk) begin
    stage[0] <= div_step(start, divisor);
    for (int k = 1; k < DIV_STAGES; k++) begin
      stage[k] <= div_step(stage[k-1], divisor);
    end
  end

  assign quotient = stage[DIV_STAGES-1].quo;

endmodule
`default_nettype wire

>>> rtl/doc_back.sv
`default_nettype none
module doc_back
  import doc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  input  wire logic        pop,
  output logic             empty,
  output logic [PIX_W-1:0] pixel_out,
  output logic [1:0]       status
);

  localparam int OPTR_W = $clog2(OUT_DEPTH);

  function automatic logic [15:0] max_level(input logic [4:0] d);
    logic [16:0] m;
    m = (17'd1 << d) - 17'd1;
    return m[15:0];
  endfunction

  logic              issue;
  logic              pop_ok;
  logic [OPTR_W:0]   reserved;

  logic [SUM_W-1:0]  dark_sum [0:PIXELS-1];
  logic [SUM_W-1:0]  dsum_rd;
  logic              s1_valid;
  item_t             s1_item;
  logic              fw_valid;
  logic [IDX_W-1:0]  fw_idx;
  logic [SUM_W-1:0]  fw_data;
  logic [SUM_W-1:0]  old_sum;
  logic [SUM_W-1:0]  sum;
  logic              sum_we;
  logic [8:0]        frames;
  logic [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]  quotient;

  logic              d_valid [0:DIV_STAGES-1];
  item_t             d_item  [0:DIV_STAGES-1];

  logic [15:0]       tgt_max;
  logic [15:0]       tgt;
  logic signed [30:0] diff;
  logic signed [COEFF_W-1:0] sat;
  logic              c_valid;
  item_t             c_item;
  logic signed [COEFF_W-1:0] c_coeff;

  logic signed [COEFF_W-1:0] offset_coeff [0:PIXELS-1];
  logic signed [COEFF_W-1:0] coeff_rd;
  logic              coef_we;
  logic              calibrated;
  logic              r_valid;
  logic              r_corr;
  status_t           r_status;
  logic [PIX_W-1:0]  r_pix;

  logic              v_valid;
  logic              v_corr;
  status_t           v_status;
  logic signed [22:0] v_val;

  logic              m_valid;
  logic              m_corr;
  status_t           m_status;
  logic              m_scaled;
  logic signed [39:0] m_val;

  logic [4:0]        cl_depth;
  logic [15:0]       out_max;
  logic signed [39:0] lim;
  logic signed [39:0] clipped;
  logic [39:0]       rounded;
  logic [PIX_W-1:0]  result;

  logic [PIX_W-1:0]  of_pix    [0:OUT_DEPTH-1];
  status_t           of_status [0:OUT_DEPTH-1];
  logic [OPTR_W-1:0] of_wp;
  logic [OPTR_W-1:0] of_rp;
  logic [OPTR_W:0]   of_cnt;

  assign issue  = q_valid && (reserved < (OPTR_W+1)'(OUT_DEPTH));
  assign q_pop  = issue;
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      case ({issue, pop_ok})
        2'b10:   reserved <= reserved + 1'b1;
        2'b01:   reserved <= reserved - 1'b1;
        default: reserved <= reserved;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dsum_rd <= dark_sum[q_item.idx];
    if (sum_we) begin
      dark_sum[s1_item.idx] <= sum;
    end
  end

  assign old_sum = (fw_valid && (fw_idx == s1_item.idx)) ? fw_data : dsum_rd;
  assign sum     = s1_item.first ? SUM_W'(s1_item.pix) : old_sum + SUM_W'(s1_item.pix);
  assign sum_we  = s1_valid && (s1_item.kind == KIND_ACC);

  always_comb begin
    if (cfg.dark_frame_count == 9'd0) begin
      frames = 9'd1;
    end else if (cfg.dark_frame_count > 9'(MAX_DARK_FRAMES)) begin
      frames = 9'(MAX_DARK_FRAMES);
    end else begin
      frames = cfg.dark_frame_count;
    end
  end

  assign dividend = {4'b0, sum, 4'b0} + DIV_W'(frames >> 1);

  always_ff @(posedge clk) begin
    s1_item <= q_item;
    fw_idx  <= s1_item.idx;
    fw_data <= sum;
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      fw_valid <= sum_we;
    end
  end

  doc_div u_div (
    .clk      (clk),
    .divisor  (frames),
    .dividend (dividend),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    d_item[0] <= s1_item;
    for (int k = 1; k < DIV_STAGES; k++) begin
      d_item[k] <= d_item[k-1];
    end
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        d_valid[k] <= 1'b0;
      end
    end else begin
      d_valid[0] <= s1_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_valid[k] <= d_valid[k-1];
      end
    end
  end

  assign tgt_max = max_level(cfg.bit_depth);
  assign tgt     = (cfg.target_baseline > tgt_max) ? tgt_max : cfg.target_baseline;
  assign diff    = $signed({11'b0, tgt, 4'b0}) - $signed({2'b0, quotient[28:0]});

  always_comb begin
    if (diff > 31'(COEFF_MAX)) begin
      sat = COEFF_W'(COEFF_MAX);
    end else if (diff < 31'(COEFF_MIN)) begin
      sat = COEFF_W'(COEFF_MIN);
    end else begin
      sat = diff[COEFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    c_item  <= d_item[DIV_STAGES-1];
    c_coeff <= (d_item[DIV_STAGES-1].kind == KIND_LOAD) ? d_item[DIV_STAGES-1].coeff : sat;
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= d_valid[DIV_STAGES-1];
    end
  end

  assign coef_we = c_valid && (((c_item.kind == KIND_ACC) && c_item.last) ||
                               (c_item.kind == KIND_LOAD));

  always_ff @(posedge clk) begin
    coeff_rd <= offset_coeff[c_item.idx];
    if (coef_we) begin
      offset_coeff[c_item.idx] <= c_coeff;
    end
  end

  always_ff @(posedge clk) begin
    r_pix  <= c_item.pix;
    r_corr <= (c_item.kind == KIND_CORRECT) && calibrated;
    if (c_item.kind == KIND_ACC_BAD) begin
      r_status <= STATUS_BAD_DEPTH;
    end else if ((c_item.kind == KIND_CORRECT) && !calibrated) begin
      r_status <= STATUS_NOT_CAL;
    end else begin
      r_status <= STATUS_OK;
    end
    if (rst) begin
      r_valid    <= 1'b0;
      calibrated <= 1'b0;
    end else begin
      r_valid <= c_valid;
      if (coef_we && ((17'(c_item.idx) + 17'd1) == cfg.active_pixels)) begin
        calibrated <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_corr   <= r_corr;
    v_status <= r_status;
    v_val    <= $signed({3'b0, r_pix, 4'b0}) + $signed({{2{coeff_rd[COEFF_W-1]}}, coeff_rd});
    if (rst) begin
      v_valid <= 1'b0;
    end else begin
      v_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    m_corr   <= v_corr;
    m_status <= v_status;
    m_scaled <= cfg.scale_enable;
    if (cfg.scale_enable) begin
      m_val <= v_val * $signed({1'b0, cfg.scale_factor});
    end else begin
      m_val <= 40'(v_val);
    end
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= v_valid;
    end
  end

  always_comb begin
    if (cfg.bit_depth == 5'd0) begin
      cl_depth = 5'd1;
    end else if (cfg.bit_depth > 5'd16) begin
      cl_depth = 5'd16;
    end else begin
      cl_depth = cfg.bit_depth;
    end
    out_max = max_level(cl_depth);
    lim = m_scaled ? $signed({8'b0, out_max, 16'b0}) : $signed({20'b0, out_max, 4'b0});
    if (m_val < 40'sd0) begin
      clipped = '0;
    end else if (m_val > lim) begin
      clipped = lim;
    end else begin
      clipped = m_val;
    end
    rounded = m_scaled ? (40'(clipped) + 40'h8000) : (40'(clipped) + 40'h8);
    result  = m_scaled ? rounded[31:16] : rounded[19:4];
  end

  always_ff @(posedge clk) begin
    if (m_valid) begin
      of_pix[of_wp]    <= m_corr ? result : '0;
      of_status[of_wp] <= m_status;
    end
    if (rst) begin
      of_wp  <= '0;
      of_rp  <= '0;
      of_cnt <= '0;
    end else begin
      if (m_valid) begin
        of_wp <= of_wp + 1'b1;
      end
      if (pop_ok) begin
        of_rp <= of_rp + 1'b1;
      end
      case ({m_valid, pop_ok})
        2'b10:   of_cnt <= of_cnt + 1'b1;
        2'b01:   of_cnt <= of_cnt - 1'b1;
        default: of_cnt <= of_cnt;
      endcase
    end
  end

  assign empty     = (of_cnt == '0);
  assign pixel_out = of_pix[of_rp];
  assign status    = of_status[of_rp];

endmodule
`default_nettype wire

>>> rtl/detector_offset_correction.sv
// Dark-frame offset correction for a detector pixel stream.
// Items enter on a queue-like port: an item is taken on a clock edge with push
// high and full low. Results leave the same way: the oldest result shows while
// empty is low and is taken on an edge with pop high. Every item gives exactly
// one result beat, in order.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// only while no item is in flight; the user must ensure this, not the block.
// Most of an item's path from push to its result is the eight-stage radix-16
// divider that forms the mean on the last dark frame, through which every item
// passes so that the coefficient store sees operations in order. One item is
// accepted every cycle while the result queue has room; the back end reserves
// a result slot per issued item.
// When the receiver stops popping, the 32-entry result queue fills, the 4-entry
// input queue fills behind it, and full rises.
// Reset clears the queues, restores the register defaults and marks the block
// uncalibrated; the accumulator and coefficient stores keep their contents.
`default_nettype none
module detector_offset_correction
  import doc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [1:0]                operation,
  input  wire logic [IDX_W-1:0]          pixel_index,
  input  wire logic [PIX_W-1:0]          pixel_value,
  input  wire logic                      first_dark_frame,
  input  wire logic                      last_dark_frame,
  input  wire logic signed [COEFF_W-1:0] coefficient_in,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [PIX_W-1:0]               pixel_out,
  output logic [1:0]                     status,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_baseline  <= 16'd2048;
      cfg.bit_depth        <= 5'd12;
      cfg.dark_frame_count <= 9'd1;
      cfg.scale_enable     <= 1'b0;
      cfg.scale_factor     <= 16'd4096;
      cfg.active_pixels    <= 17'd65536;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET:   cfg.target_baseline  <= cfg_data[15:0];
        REG_DEPTH:    cfg.bit_depth        <= cfg_data[4:0];
        REG_FRAMES:   cfg.dark_frame_count <= cfg_data[8:0];
        REG_SCALE_EN: cfg.scale_enable     <= cfg_data[0];
        REG_SCALE:    cfg.scale_factor     <= cfg_data[15:0];
        REG_ACTIVE:   cfg.active_pixels    <= cfg_data[16:0];
        default:      cfg                  <= cfg;
      endcase
    end
  end

  doc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .push             (push),
    .full             (full),
    .operation        (operation),
    .pixel_index      (pixel_index),
    .pixel_value      (pixel_value),
    .first_dark_frame (first_dark_frame),
    .last_dark_frame  (last_dark_frame),
    .coefficient_in   (coefficient_in),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  doc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .pixel_out (pixel_out),
    .status    (status)
  );

endmodule
`default_nettype wire

>>> rtl/doc_checker.sv
`default_nettype none
module doc_checker
  import doc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             full,
  input wire logic             empty,
  input wire logic             pop,
  input wire logic [PIX_W-1:0] pixel_out,
  input wire logic [1:0]       status
);

  // A result beat that reports an error carries no pixel.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != STATUS_OK)) |-> (pixel_out == '0))
    else $error("error beat with nonzero pixel");

  a_rst_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> empty)
    else $error("result queue not empty after reset");

  a_rst_full: assert property (@(posedge clk) (!rst && $past(rst)) |-> !full)
    else $error("input queue full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_out) && $stable(status)))
    else $error("waiting result beat changed");

endmodule

bind detector_offset_correction doc_checker u_doc_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .pixel_out (pixel_out),
  .status    (status)
);
`default_nettype wire

>>> verif/detector_offset_correction_test.sv
`timescale 1ns / 100ps
module detector_offset_correction_test;
  import doc_pkg::*;

  typedef struct {
    logic [15:0] pixel;
    logic [1:0]  stat;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation = OP_UNUSED;
  logic [IDX_W-1:0] pixel_index = '0;
  logic [PIX_W-1:0] pixel_value = '0;
  logic first_dark_frame = 1'b0;
  logic last_dark_frame = 1'b0;
  logic signed [COEFF_W-1:0] coefficient_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic [1:0] status;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  detector_offset_correction uut (.*);

  always #5 clk = ~clk;

  // Mirror of the block's configuration and per-pixel stores.
  int unsigned target_reg = 2048;
  int unsigned depth_reg = 12;
  int unsigned frames_reg = 1;
  int unsigned scale_en_reg = 0;
  int unsigned scale_reg = 4096;
  int unsigned active_reg = 65536;
  int unsigned dark_sums[int];
  longint offsets[int];
  bit calibrated_m = 0;

  pixel_result_t pending_pixels[$];
  int errors = 0;
  int idle_cycles = 0;
  bit steady = 0;

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void mark_complete(int idx);
    if (active_reg != 0 && active_reg <= 65536 && idx == active_reg - 1) calibrated_m = 1;
  endfunction

  function automatic pixel_result_t offset_correct(op_t op, int idx, int pix, bit first,
                                                   bit last, logic signed [20:0] cin);
    pixel_result_t res;
    longint unsigned sum, n, maxv, tgt, mean16;
    longint c, v, lim;
    int frac, d;
    res.pixel = '0;
    res.stat = STATUS_OK;
    case (op)
      OP_ACCUMULATE: begin
        if (depth_reg != 12 && depth_reg != 14 && depth_reg != 16) begin
          res.stat = STATUS_BAD_DEPTH;
        end else begin
          sum = first ? pix : (dark_sums[idx] + pix) & 24'hFFFFFF;
          dark_sums[idx] = sum;
          if (last) begin
            n = (frames_reg == 0) ? 1 : (frames_reg > MAX_DARK_FRAMES ? MAX_DARK_FRAMES
                                                                        : frames_reg);
            maxv = (64'd1 << depth_reg) - 1;
            tgt = (target_reg > maxv) ? maxv : target_reg;
            mean16 = (sum * 16 + n / 2) / n;
            c = longint'(tgt * 16) - longint'(mean16);
            if (c > COEFF_MAX) c = COEFF_MAX;
            if (c < COEFF_MIN) c = COEFF_MIN;
            offsets[idx] = c;
            mark_complete(idx);
          end
        end
      end
      OP_CORRECT: begin
        if (!calibrated_m) begin
          res.stat = STATUS_NOT_CAL;
        end else begin
          d = (depth_reg == 0) ? 1 : (depth_reg > 16 ? 16 : depth_reg);
          v = longint'(pix) * 16 + offsets[idx];
          frac = 4;
          if (scale_en_reg) begin
            v = v * scale_reg;
            frac = 16;
          end
          lim = ((64'sd1 << d) - 1) << frac;
          if (v < 0) v = 0;
          if (v > lim) v = lim;
          res.pixel = 16'((v + (64'sd1 << (frac - 1))) >>> frac);
        end
      end
      OP_LOAD: begin
        offsets[idx] = longint'(cin);
        mark_complete(idx);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(op_t op, int idx, int pix, bit first, bit last, int cin);
    int g;
    g = gap_len();
    if (g != 0) push = 1'b0;
    repeat (g) @(negedge clk);
    if (g == 0 && !push) @(negedge clk);
    push = 1'b1;
    operation = op;
    pixel_index = idx[15:0];
    pixel_value = pix[15:0];
    first_dark_frame = first;
    last_dark_frame = last;
    coefficient_in = cin[20:0];
    do @(posedge clk); while (full);
    pending_pixels.push_back(offset_correct(op, idx & 16'hFFFF, pix & 16'hFFFF, first, last,
                                            cin[20:0]));
    @(negedge clk);
  endtask

  task automatic set_reg(reg_idx_t r, int unsigned val);
    push = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data = val[16:0];
    @(negedge clk);
    cfg_write = 1'b0;
    case (r)
      REG_TARGET:   target_reg = val & 16'hFFFF;
      REG_DEPTH:    depth_reg = val & 5'h1F;
      REG_FRAMES:   frames_reg = val & 9'h1FF;
      REG_SCALE_EN: scale_en_reg = val & 1;
      REG_SCALE:    scale_reg = val & 16'hFFFF;
      REG_ACTIVE:   active_reg = val & 17'h1FFFF;
      default: ;
    endcase
  endtask

  // Random item that never reads a store entry that was never written.
  task automatic send_random(int span);
    op_t op;
    int idx, r;
    bit first;
    r = $urandom_range(99);
    op = r < 40 ? OP_CORRECT : r < 70 ? OP_ACCUMULATE : r < 90 ? OP_LOAD : OP_UNUSED;
    idx = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(span - 1);
    first = $urandom_range(3) == 0;
    if (!dark_sums.exists(idx)) first = 1;
    if (op == OP_CORRECT && calibrated_m && !offsets.exists(idx)) op = OP_LOAD;
    send_item(op, idx, $urandom_range(65535), first, $urandom_range(9) < 3,
              $urandom_range(32'h1FFFFF));
  endtask

  task automatic dark_calibration(int pixels, int frames);
    for (int f = 0; f < frames; f++)
      for (int p = 0; p < pixels; p++)
        send_item(OP_ACCUMULATE, p, $urandom_range(65535) >> $urandom_range(6), f == 0,
                  f == frames - 1, $urandom_range(32'h1FFFFF));
  endtask

  task automatic test_directed();
    send_item(OP_CORRECT, 0, 100, 0, 0, 0);
    send_item(OP_UNUSED, 5, 65535, 1, 1, -1);
    send_item(OP_LOAD, 0, 0, 0, 0, COEFF_MAX);
    send_item(OP_LOAD, 1, 0, 0, 0, COEFF_MIN);
    send_item(OP_LOAD, 65535, 65535, 1, 1, 0);
    send_item(OP_ACCUMULATE, 2, 65535, 1, 1, 0);
    send_item(OP_ACCUMULATE, 3, 0, 1, 0, 0);
    send_item(OP_ACCUMULATE, 3, 65535, 0, 1, 0);
    for (int i = 0; i < 4; i++) begin
      send_item(OP_CORRECT, i, 0, 0, 0, 0);
      send_item(OP_CORRECT, i, 65535, 1, 1, 0);
    end
    send_item(OP_CORRECT, 65535, 12345, 0, 0, 0);
    set_reg(REG_DEPTH, 10);
    send_item(OP_ACCUMULATE, 3, 500, 0, 1, 0);
    send_item(OP_CORRECT, 3, 4000, 0, 0, 0);
    send_item(OP_CORRECT, 0, 1000, 0, 0, 0);
  endtask

  task automatic test_range_extremes();
    set_reg(REG_DEPTH, 16);
    set_reg(REG_TARGET, 65535);
    set_reg(REG_FRAMES, 0);
    set_reg(REG_SCALE_EN, 1);
    set_reg(REG_SCALE, 65535);
    set_reg(REG_ACTIVE, 0);
    send_item(OP_ACCUMULATE, 6, 65535, 1, 1, 0);
    send_item(OP_CORRECT, 6, 65535, 0, 0, 0);
    send_item(OP_CORRECT, 1, 0, 0, 0, 0);
    set_reg(REG_FRAMES, 511);
    set_reg(REG_SCALE, 0);
    set_reg(REG_ACTIVE, 131071);
    send_item(OP_ACCUMULATE, 6, 1, 0, 1, 0);
    send_item(OP_CORRECT, 0, 777, 0, 0, 0);
    set_reg(REG_DEPTH, 31);
    send_item(OP_ACCUMULATE, 6, 1, 0, 1, 0);
    send_item(OP_CORRECT, 2, 70, 0, 0, 0);
    set_reg(REG_DEPTH, 0);
    send_item(OP_CORRECT, 0, 9, 0, 0, 0);
    set_reg(REG_TARGET, 0);
    set_reg(REG_SCALE_EN, 0);
    send_item(OP_CORRECT, 1, 65535, 0, 0, 0);
  endtask

  task automatic test_sum_wrap();
    set_reg(REG_DEPTH, 14);
    set_reg(REG_FRAMES, 256);
    steady = 1;
    for (int i = 0; i < 260; i++) send_item(OP_ACCUMULATE, 7, 65535, i == 0, i == 259, 0);
    steady = 0;
    send_item(OP_CORRECT, 7, 8000, 0, 0, 0);
  endtask

  task automatic test_random_phases();
    int pixels, frames;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(4))
        0: set_reg(REG_DEPTH, $urandom_range(31));
        1: set_reg(REG_DEPTH, 12);
        2: set_reg(REG_DEPTH, 14);
        default: set_reg(REG_DEPTH, 16);
      endcase
      set_reg(REG_TARGET, $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4095));
      frames = $urandom_range(4, 1);
      set_reg(REG_FRAMES, $urandom_range(5) == 0 ? $urandom_range(511) : frames);
      set_reg(REG_SCALE_EN, $urandom_range(1));
      set_reg(REG_SCALE, $urandom_range(1) ? $urandom_range(65535) : $urandom_range(8191, 2048));
      pixels = $urandom_range(8, 1);
      set_reg(REG_ACTIVE, pixels);
      steady = (ph % 3 == 2);
      dark_calibration(pixels, frames);
      for (int i = 0; i < 110; i++) send_random(pixels + 2);
    end
    steady = 0;
  endtask

  always @(negedge clk) pop = steady ? 1'b1 : (gap_len() == 0);

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out !== want.pixel)
          report($sformatf("pixel_out %0d, expected %0d", pixel_out, want.pixel));
        if (status !== want.stat)
          report($sformatf("status %0d, expected %0d", status, want.stat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 4000) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_range_extremes();
    test_sum_wrap();
    test_random_phases();
    push = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
